/* sv/als_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// als_pkg: shared definitions for the antialiased line stepper
// Default widths for the coordinate, level and error accumulator paths, and
// the line kind codes.
// ----------------------------------------------------------------------------
package als_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int LEVEL_BITS_DEF = 8;
  localparam int ACC_BITS_DEF   = 32;

  typedef enum logic [2:0] {
    KIND_HORIZ = 3'd0,
    KIND_VERT  = 3'd1,
    KIND_DIAG  = 3'd2,
    KIND_XMAJ  = 3'd3,
    KIND_YMAJ  = 3'd4
  } kind_t;

endpackage

/* sv/als_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// als_div: serial restoring divider
// Computes (dividend << Q_W) / divisor, one quotient bit per cycle. The
// dividend must be below the divisor so that the quotient fits in Q_W bits.
// ----------------------------------------------------------------------------
module als_div #(
  parameter int NUM_W = als_pkg::COORD_BITS_DEF,
  parameter int Q_W   = als_pkg::ACC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [NUM_W-1:0] divisor,
  output logic             done,
  output logic [Q_W-1:0]   quotient
);
  import als_pkg::*;

  localparam int CW = $clog2(Q_W + 1);

  logic             running;
  logic [CW-1:0]    cnt;
  logic [NUM_W-1:0] rem;
  logic [NUM_W-1:0] dvs;
  logic [NUM_W:0]   rem_dbl;
  logic [NUM_W:0]   rem_sub;
  logic             fits;

  assign rem_dbl = {rem, 1'b0};
  assign fits    = rem_dbl >= {1'b0, dvs};
  assign rem_sub = rem_dbl - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
      done    <= 1'b0;
    end else begin
      done <= running && (cnt == CW'(1));
      if (start && !running) begin
        running <= 1'b1;
        cnt     <= CW'(Q_W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          running <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !running) begin
      rem <= dividend;
      dvs <= divisor;
    end else if (running) begin
      rem      <= fits ? rem_sub[NUM_W-1:0] : rem_dbl[NUM_W-1:0];
      quotient <= {quotient[Q_W-2:0], fits};
    end
  end

  // The partial remainder stays below the divisor for the whole run.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    running |-> rem < dvs) else $error("divider remainder out of range");

  // The done pulse comes only after the iteration counter has stopped.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !running) else $error("divider done while still running");

  // A running divider always has iterations left to do.
  a_cnt_live: assert property (@(posedge clk) disable iff (rst)
    running |-> cnt != '0) else $error("divider running with zero count");

endmodule

/* sv/antialiased_line_stepper.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// antialiased_line_stepper: Wu antialiased line generator
// A start item loads two endpoints and emits the first pixel; each step item
// emits the next pixel, or a weighted pixel pair for x-major and y-major
// lines. The far endpoint is flagged last.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake          payload
//  s_*       in         s_tvalid/s_tready  s_tuser: op
//                                          s_tdata: x_start, y_start, x_end, y_end
//  m_*       out        m_tvalid/m_tready  m_tdata: px, py, level, off_grid
//                                          m_tlast: last
//
//  A step item that yields a pixel pair holds off input until the second
//  pixel has moved up, since both pixels leave through a single output
//  register. A start item of an x-major or y-major line occupies the
//  shared serial divider, one quotient bit per cycle, and no item is
//  accepted until the error step is in place.
//  Reset (rst, synchronous) returns the block to idle with no line running.
//  An output stall holds the pixel in the output register and blocks input.
// ----------------------------------------------------------------------------
module antialiased_line_stepper #(
  parameter int COORD_BITS = als_pkg::COORD_BITS_DEF,
  parameter int LEVEL_BITS = als_pkg::LEVEL_BITS_DEF,
  parameter int ACC_BITS   = als_pkg::ACC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // s_tdata, low bit up: x_start, y_start, x_end, y_end, zero fill
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]       s_tdata,
  // s_tuser: op (0 start a line, 1 advance one step)
  input  logic                                    s_tuser,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // m_tdata, low bit up: px, py, level, off_grid, zero fill
  output logic [((2*COORD_BITS+LEVEL_BITS+8)/8)*8-1:0] m_tdata,
  // m_tlast: last pixel of the line
  output logic                                    m_tlast
);
  import als_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int OUT_W = ((2*COORD_BITS+LEVEL_BITS+8)/8)*8;

  // The sequencer: idle and ready, second pixel of a pair pending, or
  // waiting for the divider to deliver the error step.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_PAIR = 3'b010,
    S_DIV  = 3'b100
  } state_t;

  state_t                state;
  logic                  line_busy;
  kind_t                 line_kind;
  logic [C-1:0]          cur_x, cur_y, far_x, far_y;
  logic                  x_backward;
  logic [C-1:0]          steps_left;
  logic [ACC_BITS-1:0]   err_acc, err_step;

  // Output register and the pending neighbour pixel.
  logic                  out_valid;
  logic [C-1:0]          out_x, out_y;
  logic [LEVEL_BITS-1:0] out_lvl;
  logic                  out_off, out_last;
  logic [C-1:0]          pend_x, pend_y;
  logic [LEVEL_BITS-1:0] pend_lvl;
  logic                  pend_off;

  logic accept, out_free, out_load;

  // Start decode.
  logic [C-1:0] xs, ys, xe, ye, x0, y0, x1, y1, dx, dy;
  logic [C-1:0] st_steps, div_minor, div_major;
  logic         st_back;
  kind_t        st_kind;

  // Step datapath.
  logic [ACC_BITS:0]     acc_sum;
  logic                  wrap, final_step, weighted;
  logic [C-1:0]          cx_adv, cy_inc;
  logic [C-1:0]          nx_cur, ny_cur, nb_x, nb_y;
  logic                  nb_off;
  logic [LEVEL_BITS-1:0] wgt;

  logic                div_start, div_done;
  logic [ACC_BITS-1:0] div_q;

  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == S_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;

  // A new pixel enters the output register on a start, on a step of a
  // running line, or when the pending neighbour of a pair moves up.
  assign out_load = (accept && (!s_tuser || line_busy)) ||
                    (state == S_PAIR && out_free);

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = OUT_W'({out_off, out_lvl, out_y, out_x});

  // Endpoints are ordered so that y rises, then the line is classified.
  // The minor and major deltas feed the divider for the weighted kinds.
  always_comb begin
    xs = s_tdata[C-1:0];
    ys = s_tdata[2*C-1:C];
    xe = s_tdata[3*C-1:2*C];
    ye = s_tdata[4*C-1:3*C];
    if (ys > ye) begin
      x0 = xe; y0 = ye; x1 = xs; y1 = ys;
    end else begin
      x0 = xs; y0 = ys; x1 = xe; y1 = ye;
    end
    st_back   = x1 < x0;
    dx        = st_back ? x0 - x1 : x1 - x0;
    dy        = y1 - y0;
    div_minor = dx;
    div_major = dy;
    if (dy == '0) begin
      st_kind  = KIND_HORIZ;
      st_steps = dx;
    end else if (dx == '0) begin
      st_kind  = KIND_VERT;
      st_steps = dy;
    end else if (dx == dy) begin
      st_kind  = KIND_DIAG;
      st_steps = dy;
    end else if (dy > dx) begin
      st_kind  = KIND_YMAJ;
      st_steps = dy;
    end else begin
      st_kind   = KIND_XMAJ;
      st_steps  = dx;
      div_minor = dy;
      div_major = dx;
    end
  end

  assign div_start = accept && !s_tuser &&
                     (st_kind == KIND_XMAJ || st_kind == KIND_YMAJ);

  // One step of the line. The accumulator wraps when the sum carries out,
  // or when the error step is zero and the sum equals the old value.
  always_comb begin
    acc_sum    = {1'b0, err_acc} + {1'b0, err_step};
    wrap       = acc_sum[ACC_BITS] || (err_step == '0);
    final_step = steps_left[C-1:1] == '0;
    weighted   = (line_kind == KIND_XMAJ) || (line_kind == KIND_YMAJ);
    cx_adv     = x_backward ? cur_x - 1'b1 : cur_x + 1'b1;
    cy_inc     = cur_y + 1'b1;
    wgt        = acc_sum[ACC_BITS-1 -: LEVEL_BITS];
    nx_cur     = cur_x;
    ny_cur     = cur_y;
    nb_x       = cur_x;
    nb_y       = cur_y;
    nb_off     = 1'b0;
    case (line_kind)
      KIND_HORIZ: begin
        nx_cur = cx_adv;
      end
      KIND_VERT: begin
        ny_cur = cy_inc;
      end
      KIND_DIAG: begin
        nx_cur = cx_adv;
        ny_cur = cy_inc;
      end
      KIND_YMAJ: begin
        // Neighbour sits one column further along x.
        nx_cur = wrap ? cx_adv : cur_x;
        ny_cur = cy_inc;
        nb_x   = x_backward ? nx_cur - 1'b1 : nx_cur + 1'b1;
        nb_y   = ny_cur;
        nb_off = x_backward ? (nx_cur == '0) : (nx_cur == '1);
      end
      KIND_XMAJ: begin
        // Neighbour sits one row below.
        nx_cur = cx_adv;
        ny_cur = wrap ? cy_inc : cur_y;
        nb_x   = nx_cur;
        nb_y   = ny_cur + 1'b1;
        nb_off = ny_cur == '1;
      end
      default: begin
        nx_cur = cur_x;
        ny_cur = cur_y;
      end
    endcase
  end

  als_div #(
    .NUM_W (C),
    .Q_W   (ACC_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_minor),
    .divisor  (div_major),
    .done     (div_done),
    .quotient (div_q)
  );

  // Control state: sequencer, line status and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      line_busy  <= 1'b0;
      line_kind  <= KIND_HORIZ;
      steps_left <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (!s_tuser) begin
              line_kind  <= st_kind;
              steps_left <= st_steps;
              line_busy  <= st_steps != '0;
              if (div_start) begin
                state <= S_DIV;
              end
            end else if (line_busy) begin
              if (final_step) begin
                steps_left <= '0;
                line_busy  <= 1'b0;
              end else begin
                steps_left <= steps_left - 1'b1;
                if (weighted) begin
                  state <= S_PAIR;
                end
              end
            end
          end
        end
        S_PAIR: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Line geometry and error terms.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x      <= '0;
      cur_y      <= '0;
      far_x      <= '0;
      far_y      <= '0;
      x_backward <= 1'b0;
      err_acc    <= '0;
      err_step   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && !s_tuser) begin
            cur_x      <= x0;
            cur_y      <= y0;
            far_x      <= x1;
            far_y      <= y1;
            x_backward <= st_back;
            err_acc    <= '0;
            err_step   <= '0;
          end else if (accept && line_busy) begin
            if (final_step) begin
              cur_x <= far_x;
              cur_y <= far_y;
            end else begin
              cur_x <= nx_cur;
              cur_y <= ny_cur;
              if (weighted) begin
                err_acc <= acc_sum[ACC_BITS-1:0];
              end
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            err_step <= div_q;
          end
        end
        default: begin
          err_step <= err_step;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      if (!s_tuser) begin
        out_x    <= x0;
        out_y    <= y0;
        out_lvl  <= '0;
        out_off  <= 1'b0;
        out_last <= st_steps == '0;
      end else if (line_busy) begin
        out_off <= 1'b0;
        if (final_step) begin
          out_x    <= far_x;
          out_y    <= far_y;
          out_lvl  <= '0;
          out_last <= 1'b1;
        end else begin
          out_x    <= nx_cur;
          out_y    <= ny_cur;
          out_lvl  <= weighted ? wgt : '0;
          out_last <= 1'b0;
          pend_x   <= nb_x;
          pend_y   <= nb_y;
          pend_lvl <= ~wgt;
          pend_off <= nb_off;
        end
      end
    end else if (state == S_PAIR && out_free) begin
      out_x    <= pend_x;
      out_y    <= pend_y;
      out_lvl  <= pend_lvl;
      out_off  <= pend_off;
      out_last <= 1'b0;
    end
  end

  // A pending neighbour always follows a main pixel still in the output.
  a_pair_has_main: assert property (@(posedge clk) disable iff (rst)
    state == S_PAIR |-> out_valid) else $error("pair pending without main pixel");

  // Only weighted lines wait for the divider.
  a_div_kind: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> (line_kind == KIND_XMAJ || line_kind == KIND_YMAJ))
    else $error("divider wait on an unweighted line");

  // Unweighted kinds never carry an error step.
  a_step_zero: assert property (@(posedge clk) disable iff (rst)
    (line_kind == KIND_HORIZ || line_kind == KIND_VERT || line_kind == KIND_DIAG)
    |-> err_step == '0) else $error("error step set on an unweighted line");

  // An idle line has no steps left.
  a_idle_steps: assert property (@(posedge clk) disable iff (rst)
    !line_busy |-> steps_left == '0) else $error("steps left on an idle line");

endmodule
